/* rtl/core/bacc_pkg.sv */
`default_nettype none

package bacc_pkg;

    // Parameter defaults for the top level
    localparam int DEF_NUM_REFERENCES = 4;
    localparam int DEF_BINS_PER_ARRAY = 4096;
    localparam int DEF_COUNT_BITS     = 32;

    // Field widths
    localparam int POS_W       = 32;
    localparam int LEN_W       = 28;
    localparam int BIN_SIZE_W  = 16;
    localparam int MAPQ_W      = 8;
    localparam int FLAGS_W     = 16;
    localparam int REF_W       = 2;
    localparam int KIND_W      = 2;
    localparam int SEL_W       = 2;
    localparam int BIN_IDX_W   = 12;
    localparam int STATUS_W    = 2;
    localparam int OUT_COUNT_W = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // SAM flag 256 (secondary alignment)
    localparam int SECONDARY_BIT = 8;

    localparam logic [BIN_SIZE_W-1:0] BIN_SIZE_RST = 16'd10;
    localparam logic [MAPQ_W-1:0]     MIN_MAPQ_RST = 8'd10;

    // Operation kinds, which double as array selects
    localparam logic [KIND_W-1:0] KIND_MATCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INS   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FILTERED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAPQ = 2'd1;

endpackage

`default_nettype wire

/* rtl/core/binned_alignment_coverage_counter.sv */
`default_nettype none

// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+---------------------------------------
// command   | in        | start / busy                 | i_command .. i_bin_index
// result    | out       | o_result_strobe (one cycle)  | o_status, o_count
// config    | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// Items filtered, ignored or rejected on accept finish straight from idle; a counter read
// passes through the read and write states; a run wholly outside the store ends at the
// range check and an insertion beyond the store once the divider is done. An insertion or
// a match or deletion run uses the position / bin_size divider, then a read-modify-write
// of the counter memory (one port pair, one bin per pass) for each bin touched.
// Reset: after i_rst_n the block sweeps the counter memory to zero, one entry a cycle,
// through all NUM_REFERENCES*3*BINS_PER_ARRAY entries (49152 by default), holding busy high.
// Config beats are always taken. The receiver cannot stall; each result shows for one cycle.
module binned_alignment_coverage_counter #(
    parameter int NUM_REFERENCES = bacc_pkg::DEF_NUM_REFERENCES,
    parameter int BINS_PER_ARRAY = bacc_pkg::DEF_BINS_PER_ARRAY,
    parameter int COUNT_BITS     = bacc_pkg::DEF_COUNT_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_command,
    input  wire logic                            i_first_op,
    input  wire logic [bacc_pkg::REF_W-1:0]       i_reference_index,
    input  wire logic [bacc_pkg::POS_W-1:0]       i_start_position,
    input  wire logic [bacc_pkg::FLAGS_W-1:0]     i_alignment_flags,
    input  wire logic [bacc_pkg::MAPQ_W-1:0]      i_map_quality,
    input  wire logic [bacc_pkg::KIND_W-1:0]      i_op_kind,
    input  wire logic [bacc_pkg::LEN_W-1:0]       i_op_length,
    input  wire logic [bacc_pkg::SEL_W-1:0]       i_array_select,
    input  wire logic [bacc_pkg::BIN_IDX_W-1:0]   i_bin_index,
    output logic                                 o_result_strobe,
    output logic [bacc_pkg::STATUS_W-1:0]         o_status,
    output logic [bacc_pkg::OUT_COUNT_W-1:0]      o_count,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [bacc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bacc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bacc_pkg::*;

    localparam int DEPTH  = NUM_REFERENCES * 3 * BINS_PER_ARRAY;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = $clog2(NUM_REFERENCES * 3);
    localparam int BIN_W  = (BINS_PER_ARRAY > 1) ? $clog2(BINS_PER_ARRAY) : 1;
    localparam int SE_W   = BIN_SIZE_W + $clog2(BINS_PER_ARRAY + 1);
    localparam int P_W    = ((SE_W > POS_W + 1) ? SE_W : POS_W + 1) + 1;
    localparam int SUM_W  = ((COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W) + 1;
    localparam int CX_W   = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_RANGE,
        S_DIV,
        S_RD,
        S_WR
    } t_state;

    t_state                  r_state;
    logic [ADDR_W-1:0]       r_clr;
    logic                    r_strobe;
    logic [STATUS_W-1:0]     r_status;
    logic [OUT_COUNT_W-1:0]  r_count;

    logic [BIN_SIZE_W-1:0]   r_bin_size;
    logic [MAPQ_W-1:0]       r_min_mapq;

    logic [POS_W-1:0]        r_ref_position;
    logic [REF_W-1:0]        r_cur_ref;
    logic                    r_kept;

    logic                    r_is_read;
    logic [KIND_W-1:0]       r_kind;
    logic [LEN_W-1:0]        r_len;
    logic [ROW_W-1:0]        r_row;
    logic [POS_W-1:0]        r_bin;
    logic [POS_W:0]          r_end;
    logic [P_W-1:0]          r_store_end;
    logic [P_W-1:0]          r_ec;
    logic                    r_drop;
    logic [P_W-1:0]          r_cur;
    logic [P_W-1:0]          r_bin_end;
    logic [LEN_W-1:0]        r_amount;
    logic                    r_last;

    logic [COUNT_BITS-1:0]   r_mem [DEPTH];
    logic [COUNT_BITS-1:0]   r_rdata;

    logic [BIN_SIZE_W-1:0]   bs_eff;
    logic                    kept_in;
    logic                    kept_now;
    logic [REF_W-1:0]        ref_now;
    logic                    rd_bad;
    logic [ROW_W-1:0]        rd_row;
    logic [ROW_W-1:0]        op_row;
    logic [KIND_W-1:0]       op_arr;
    logic [P_W-1:0]          pos_lim;
    logic [P_W-1:0]          end_w;
    logic [P_W-1:0]          ec1;
    logic [P_W-1:0]          ec;
    logic                    drop;
    logic [P_W-1:0]          hi;
    logic [ADDR_W-1:0]       mem_addr;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [COUNT_BITS-1:0]   mem_wdata;
    logic [SUM_W-1:0]        sum;
    logic [COUNT_BITS-1:0]   sat_sum;
    logic [CX_W-1:0]         rd_ext;
    logic [OUT_COUNT_W-1:0]  count_out;

    logic                    div_start;
    logic                    div_done;
    logic [POS_W-1:0]        div_q;
    logic [BIN_SIZE_W-1:0]   div_r;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign bs_eff   = (r_bin_size == '0) ? BIN_SIZE_W'(1) : r_bin_size;
    assign kept_in  = !i_alignment_flags[SECONDARY_BIT] && (i_map_quality >= r_min_mapq);
    assign kept_now = i_first_op ? kept_in : r_kept;
    assign ref_now  = i_first_op ? i_reference_index : r_cur_ref;
    assign rd_bad   = (i_array_select > KIND_INS)
                   || (32'(i_bin_index) >= 32'(BINS_PER_ARRAY))
                   || (32'(i_reference_index) >= 32'(NUM_REFERENCES));
    assign rd_row   = ROW_W'(32'(i_reference_index) * 3 + 32'(i_array_select));
    assign op_arr   = (i_op_kind == KIND_INS) ? KIND_INS : i_op_kind;
    assign op_row   = ROW_W'(32'(ref_now) * 3 + 32'(op_arr));

    // Run end clipped to the position limit and the end of the store
    assign pos_lim = P_W'(1) << POS_W;
    assign end_w   = P_W'(r_end);
    assign ec1     = r_end[POS_W] ? pos_lim : end_w;
    assign ec      = (ec1 > r_store_end) ? r_store_end : ec1;
    assign drop    = (end_w > pos_lim) || (ec1 > r_store_end);

    assign hi = (r_bin_end < r_ec) ? r_bin_end : r_ec;

    assign mem_addr = ADDR_W'(32'(r_row) * 32'(BINS_PER_ARRAY) + 32'(r_bin[BIN_W-1:0]));

    assign sum     = SUM_W'(r_rdata) + SUM_W'(r_amount);
    assign sat_sum = (sum >= SUM_W'({COUNT_BITS{1'b1}})) ? {COUNT_BITS{1'b1}}
                                                        : sum[COUNT_BITS-1:0];

    assign rd_ext    = CX_W'(r_rdata);
    assign count_out = (rd_ext > CX_W'({OUT_COUNT_W{1'b1}})) ? {OUT_COUNT_W{1'b1}}
                                                             : rd_ext[OUT_COUNT_W-1:0];

    assign mem_we    = (r_state == S_CLEAR) || ((r_state == S_WR) && !r_is_read);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr : mem_addr;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : sat_sum;

    assign div_start = (r_state == S_PREP);

    bacc_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_ref_position),
        .i_divisor   (bs_eff),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    // Counter memory. Items run one at a time and each write lands before the
    // next read of any entry, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_strobe       <= 1'b0;
            r_bin_size     <= BIN_SIZE_RST;
            r_min_mapq     <= MIN_MAPQ_RST;
            r_ref_position <= '0;
            r_cur_ref      <= '0;
            r_kept         <= 1'b0;
        end else begin
            r_strobe <= 1'b0;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BIN_SIZE: r_bin_size <= i_cfg_data;
                    CFG_MIN_MAPQ: r_min_mapq <= i_cfg_data[MAPQ_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (start) begin
                        r_is_read <= i_command;
                        r_kind    <= i_op_kind;
                        r_len     <= i_op_length;
                        if (i_command) begin
                            if (rd_bad) begin
                                r_strobe <= 1'b1;
                                r_status <= ST_RANGE;
                                r_count  <= '0;
                            end else begin
                                r_row   <= rd_row;
                                r_bin   <= POS_W'(i_bin_index);
                                r_state <= S_RD;
                            end
                        end else begin
                            if (i_first_op) begin
                                r_cur_ref      <= i_reference_index;
                                r_ref_position <= (i_start_position == '0) ? '0
                                                  : i_start_position - 1'b1;
                                r_kept         <= kept_in;
                            end
                            if (!kept_now) begin
                                r_strobe <= 1'b1;
                                r_status <= ST_FILTERED;
                                r_count  <= '0;
                            end else if (i_op_kind == KIND_OTHER || i_op_length == '0) begin
                                r_strobe <= 1'b1;
                                r_status <= ST_DONE;
                                r_count  <= '0;
                            end else if (32'(ref_now) >= 32'(NUM_REFERENCES)) begin
                                r_strobe <= 1'b1;
                                r_status <= ST_RANGE;
                                r_count  <= '0;
                            end else begin
                                r_row   <= op_row;
                                r_state <= S_PREP;
                            end
                        end
                    end
                end

                S_PREP: begin
                    r_store_end <= P_W'(bs_eff) * P_W'(BINS_PER_ARRAY);
                    r_end       <= (POS_W + 1)'(r_ref_position) + (POS_W + 1)'(r_len);
                    r_state     <= S_RANGE;
                end

                S_RANGE: begin
                    if (r_kind == KIND_INS) begin
                        r_state <= S_DIV;
                    end else begin
                        r_ec           <= ec;
                        r_drop         <= drop;
                        r_cur          <= P_W'(r_ref_position);
                        r_ref_position <= r_end[POS_W] ? {POS_W{1'b1}} : r_end[POS_W-1:0];
                        if (P_W'(r_ref_position) >= ec) begin
                            // nothing of the run lies inside the store
                            r_strobe <= 1'b1;
                            r_status <= ST_RANGE;
                            r_count  <= '0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end

                S_DIV: begin
                    if (div_done) begin
                        if (r_kind == KIND_INS) begin
                            if (div_q >= POS_W'(BINS_PER_ARRAY)) begin
                                r_strobe <= 1'b1;
                                r_status <= ST_RANGE;
                                r_count  <= '0;
                                r_state  <= S_IDLE;
                            end else begin
                                r_bin    <= div_q;
                                r_amount <= r_len;
                                r_last   <= 1'b1;
                                r_state  <= S_RD;
                            end
                        end else begin
                            r_bin     <= div_q;
                            // first bin boundary above the run start
                            r_bin_end <= r_cur - P_W'(div_r) + P_W'(bs_eff);
                            r_state   <= S_RD;
                        end
                    end
                end

                S_RD: begin
                    if (!r_is_read && r_kind != KIND_INS) begin
                        r_amount <= LEN_W'(hi - r_cur);
                        r_last   <= (r_bin_end >= r_ec);
                        r_cur    <= hi;
                    end
                    r_state <= S_WR;
                end

                S_WR: begin
                    if (r_is_read) begin
                        r_strobe <= 1'b1;
                        r_status <= ST_DONE;
                        r_count  <= count_out;
                        r_state  <= S_IDLE;
                    end else if (r_last) begin
                        r_strobe <= 1'b1;
                        r_status <= (r_kind != KIND_INS && r_drop) ? ST_RANGE : ST_DONE;
                        r_count  <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_bin     <= r_bin + 1'b1;
                        r_bin_end <= r_bin_end + P_W'(bs_eff);
                        r_state   <= S_RD;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_status        = r_status;
    assign o_count         = r_count;

endmodule

`default_nettype wire

/* rtl/core/bacc_divider.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module bacc_divider (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [bacc_pkg::POS_W-1:0]      i_dividend,
    input  wire logic [bacc_pkg::BIN_SIZE_W-1:0] i_divisor,
    output logic                                o_done,
    output logic [bacc_pkg::POS_W-1:0]           o_quotient,
    output logic [bacc_pkg::BIN_SIZE_W-1:0]      o_remainder
);
    import bacc_pkg::*;

    localparam int CNT_W = $clog2(POS_W);

    logic [POS_W-1:0]      r_quo;
    logic [BIN_SIZE_W-1:0] r_rem;
    logic [BIN_SIZE_W-1:0] r_dvs;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_run;
    logic                  r_done;

    logic [BIN_SIZE_W:0]   trial;
    logic [BIN_SIZE_W:0]   diff;
    logic                  fits;
    logic [BIN_SIZE_W-1:0] n_rem;

    assign trial = {r_rem, r_quo[POS_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};
    // partial remainder stays below the divisor, so it fits in BIN_SIZE_W bits
    assign n_rem = fits ? diff[BIN_SIZE_W-1:0] : trial[BIN_SIZE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo <= i_dividend;
                r_rem <= '0;
                r_dvs <= i_divisor;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_quo <= {r_quo[POS_W-2:0], fits};
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(POS_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

/* rtl/core/bacc_checker.sv */
`default_nettype none

module bacc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic                           o_result_strobe,
    input wire logic [bacc_pkg::STATUS_W-1:0]    o_status,
    input wire logic [bacc_pkg::OUT_COUNT_W-1:0] o_count
);
    import bacc_pkg::*;

    // a result beat always leaves the block ready for the next command
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !busy)
        else $error("result beat while busy");

    // an accepted command either finishes at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_strobe))
        else $error("accepted command dropped");

    // no result beat without a command behind it
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy || start))
        else $error("result beat without command");

    // rejected and filtered items carry a zero count
    a_error_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && (o_status == ST_FILTERED || o_status == ST_RANGE))
        |-> (o_count == '0))
        else $error("nonzero count on error status");

endmodule

bind binned_alignment_coverage_counter bacc_checker u_bacc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_status        (o_status),
    .o_count         (o_count)
);

`default_nettype wire
